@@ rtl/core/slpf_pkg.sv @@
// Shared types and constants for the sensor level percent filter.
package slpf_pkg;

    localparam int CODE_W     = 12;
    localparam int PCT_W      = 8;
    localparam int Q16_W      = 20;
    localparam int LIMIT_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int FRAC_W     = 16;
    localparam int SLOPE_PROD_W = CODE_W + Q16_W;
    localparam int LVL_PROD_W   = PCT_W + Q16_W;

    localparam logic [PCT_W-1:0]  INVALID_MARK = 8'hFF;
    localparam logic [PCT_W-1:0]  OUT_MAX      = 8'd254;
    localparam logic [FRAC_W-1:0] HALF_Q16     = 16'h8000;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_CODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_RECIP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FAIL_LIMIT = 3'd4;

    typedef struct packed {
        logic [CODE_W-1:0]  min_code;
        logic [CODE_W-1:0]  max_code;
        logic [Q16_W-1:0]   slope_q16;
        logic [Q16_W-1:0]   level_recip_q16;
        logic [LIMIT_W-1:0] fail_limit;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_CHECK,
        ST_PCT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic upd;
        logic div;
        logic check;
        logic pct;
        logic fin;
    } cmd_t;

endpackage

@@ rtl/core/slpf_in_if.sv @@
// Input channel: one burst of raw converter samples per beat.
interface slpf_in_if;
    logic                       valid;
    logic                       ready;
    logic [slpf_pkg::CODE_W-1:0] sample_a;
    logic [slpf_pkg::CODE_W-1:0] sample_b;
    logic [slpf_pkg::CODE_W-1:0] sample_c;
    logic [slpf_pkg::CODE_W-1:0] sample_d;

    modport source (output valid, output sample_a, output sample_b, output sample_c,
                    output sample_d, input ready);
    modport sink (input valid, input sample_a, input sample_b, input sample_c,
                  input sample_d, output ready);
endinterface

@@ rtl/core/slpf_out_if.sv @@
// Output channel: one filtered reading per beat.
interface slpf_out_if;
    logic                        valid;
    logic                        ready;
    logic [slpf_pkg::PCT_W-1:0]  percent;
    logic [slpf_pkg::PCT_W-1:0]  level;
    logic [slpf_pkg::CODE_W-1:0] filtered_code;
    logic                        in_range;

    modport source (output valid, output percent, output level, output filtered_code,
                    output in_range, input ready);
    modport sink (input valid, input percent, input level, input filtered_code,
                  input in_range, output ready);
endinterface

@@ rtl/core/slpf_cfg_if.sv @@
// Configuration write channel: register index and write data per beat.
interface slpf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [slpf_pkg::CFG_IDX_W-1:0]  index;
    logic [slpf_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/sensor_level_percent_filter_top.sv @@
// Top level of the sensor level percent filter.
// Each beat on samples carries a burst of converter samples; the block floors
// their mean, pushes it into a WINDOW_DEPTH-entry moving-average window that
// starts at all zeros and always divides by the full depth, then checks the
// filtered code against [min_code, max_code]. In range, percent is
// round((code - min_code) * slope_q16 / 2^16) and level is
// round(percent * level_recip_q16 / 2^16), both capped at 254; out of range
// the last values hold and a fail counter advances, and when it reaches
// fail_limit both outputs become 255 (invalid). One result beat per input
// beat. The burst mean and window read happen at the accepting edge; the
// single shared datapath then steps through running-sum update, reciprocal
// multiply for the division by depth, range check with slope multiply,
// percent rounding with level multiply, and final rounding, which loads the
// output register. The next burst is accepted in the cycle after that load,
// even while the previous result still waits on result.ready. If a result
// still waits when the next burst reaches its final step, that step holds
// until result.ready, and the burst after it waits too.
// The window needs no clearing pass after reset. Write configuration only
// while the block is idle.
module sensor_level_percent_filter_top #(
    parameter int WINDOW_DEPTH = 8,
    parameter int BURST_SIZE   = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    slpf_in_if.sink      samples,
    slpf_out_if.source   result,
    slpf_cfg_if.sink     cfg
);

    slpf_pkg::cfg_t regs;
    slpf_pkg::cmd_t cmd;

    slpf_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    slpf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    slpf_dpath #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .BURST_SIZE   (BURST_SIZE)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .regs          (regs),
        .sample_a      (samples.sample_a),
        .sample_b      (samples.sample_b),
        .sample_c      (samples.sample_c),
        .sample_d      (samples.sample_d),
        .percent       (result.percent),
        .level         (result.level),
        .filtered_code (result.filtered_code),
        .in_range      (result.in_range)
    );

endmodule

@@ rtl/core/slpf_cfg_regs.sv @@
// Configuration register file written through the configuration channel.
module slpf_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    slpf_cfg_if.sink      cfg,
    output slpf_pkg::cfg_t regs
);

    slpf_pkg::cfg_t regs_reg;
    slpf_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                slpf_pkg::REG_MIN_CODE:
                    regs_next.min_code = cfg.data[slpf_pkg::CODE_W-1:0];
                slpf_pkg::REG_MAX_CODE:
                    regs_next.max_code = cfg.data[slpf_pkg::CODE_W-1:0];
                slpf_pkg::REG_SLOPE:
                    regs_next.slope_q16 = cfg.data[slpf_pkg::Q16_W-1:0];
                slpf_pkg::REG_LEVEL_RECIP:
                    regs_next.level_recip_q16 = cfg.data[slpf_pkg::Q16_W-1:0];
                slpf_pkg::REG_FAIL_LIMIT:
                    regs_next.fail_limit = cfg.data[slpf_pkg::LIMIT_W-1:0];
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.min_code        <= 12'd0;
            regs_reg.max_code        <= 12'd4095;
            regs_reg.slope_q16       <= 20'd1600;
            regs_reg.level_recip_q16 <= 20'd6554;
            regs_reg.fail_limit      <= 16'd10;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

@@ rtl/core/slpf_ctrl.sv @@
// Sequencer that steps one burst through the filter datapath.
module slpf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output slpf_pkg::cmd_t      cmd
);

    slpf_pkg::state_t state_reg;
    slpf_pkg::state_t state_next;
    logic             out_vld_reg;
    logic             out_vld_next;
    logic             out_free;

    assign out_free  = !out_vld_reg || out_ready;
    assign out_valid = out_vld_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            slpf_pkg::ST_IDLE:
                if (in_valid)
                    state_next = slpf_pkg::ST_SUM;
            slpf_pkg::ST_SUM:   state_next = slpf_pkg::ST_DIV;
            slpf_pkg::ST_DIV:   state_next = slpf_pkg::ST_CHECK;
            slpf_pkg::ST_CHECK: state_next = slpf_pkg::ST_PCT;
            slpf_pkg::ST_PCT:   state_next = slpf_pkg::ST_FIN;
            slpf_pkg::ST_FIN:
                // hold until the output register can take the result
                if (out_free)
                    state_next = slpf_pkg::ST_IDLE;
            default:            state_next = slpf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            slpf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            slpf_pkg::ST_SUM:   cmd.upd   = 1'b1;
            slpf_pkg::ST_DIV:   cmd.div   = 1'b1;
            slpf_pkg::ST_CHECK: cmd.check = 1'b1;
            slpf_pkg::ST_PCT:   cmd.pct   = 1'b1;
            slpf_pkg::ST_FIN:   cmd.fin   = out_free;
            default:            cmd       = '0;
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (out_ready)
            out_vld_next = 1'b0;
        if (cmd.fin)
            out_vld_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= slpf_pkg::ST_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

endmodule

@@ rtl/core/slpf_dpath.sv @@
// Datapath: burst mean, moving-average window, range check and Q16 scaling.
module slpf_dpath #(
    parameter int WINDOW_DEPTH = 8,
    parameter int BURST_SIZE   = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  slpf_pkg::cmd_t                cmd,
    input  slpf_pkg::cfg_t                regs,
    input  logic [slpf_pkg::CODE_W-1:0]   sample_a,
    input  logic [slpf_pkg::CODE_W-1:0]   sample_b,
    input  logic [slpf_pkg::CODE_W-1:0]   sample_c,
    input  logic [slpf_pkg::CODE_W-1:0]   sample_d,
    output logic [slpf_pkg::PCT_W-1:0]    percent,
    output logic [slpf_pkg::PCT_W-1:0]    level,
    output logic [slpf_pkg::CODE_W-1:0]   filtered_code,
    output logic                          in_range
);

    localparam int CODE_W  = slpf_pkg::CODE_W;
    localparam int PCT_W   = slpf_pkg::PCT_W;
    localparam int SLOT_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W   = CODE_W + SLOT_W;
    // floor(x / depth) as (x * RECIP_M) >> RECIP_SH, exact for x below 2^SUM_W
    localparam int RECIP_SH = SUM_W + SLOT_W;
    localparam int RECIP_W  = SUM_W + 1;
    localparam int RECIP_M  = ((1 << RECIP_SH) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
    localparam int DIV_W    = SUM_W + RECIP_W;
    localparam int NSAMP    = (BURST_SIZE > 4) ? 4 : ((BURST_SIZE < 1) ? 1 : BURST_SIZE);
    localparam int BSUM_W   = CODE_W + 2;
    localparam int THIRD_W  = 16;
    localparam logic [THIRD_W-1:0] THIRD_Q16 = 16'd21846;
    localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
    localparam int SP_W = slpf_pkg::SLOPE_PROD_W;
    localparam int LP_W = slpf_pkg::LVL_PROD_W;
    localparam int FR_W = slpf_pkg::FRAC_W;

    // window store and its per-entry valid bits (entries read as zero until written)
    logic [CODE_W-1:0]       win_mem [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] win_vld_reg;
    logic [WINDOW_DEPTH-1:0] win_vld_next;

    logic [CODE_W-1:0]  mean_reg;
    logic [CODE_W-1:0]  old_reg;
    logic               old_vld_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  slot_next;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [DIV_W-1:0]   div_prod_reg;
    logic [CODE_W-1:0]  code_reg;
    logic               ok_reg;
    logic [SP_W-1:0]    pct_prod_reg;
    logic [PCT_W-1:0]   pct_reg;
    logic [LP_W-1:0]    lvl_prod_reg;
    logic [slpf_pkg::LIMIT_W-1:0] fail_reg;
    logic [slpf_pkg::LIMIT_W-1:0] fail_next;
    logic [PCT_W-1:0]   held_pct_reg;
    logic [PCT_W-1:0]   held_pct_next;
    logic [PCT_W-1:0]   held_lvl_reg;
    logic [PCT_W-1:0]   held_lvl_next;
    logic [PCT_W-1:0]   out_pct_reg;
    logic [PCT_W-1:0]   out_lvl_reg;
    logic [CODE_W-1:0]  out_code_reg;
    logic               out_ok_reg;

    logic [BSUM_W-1:0]          burst_sum;
    logic [BSUM_W+THIRD_W-1:0]  third_prod;
    logic [CODE_W-1:0]          mean;
    logic [CODE_W-1:0]          old_val;
    logic [CODE_W-1:0]          code;
    logic                       ok;
    logic [CODE_W-1:0]          offset;
    logic [SP_W:0]              pct_rnd;
    logic [PCT_W-1:0]           pct_sat;
    logic [LP_W:0]              lvl_rnd;
    logic [PCT_W-1:0]           lvl_sat;
    logic [slpf_pkg::LIMIT_W-1:0] fail_inc;

    // burst mean over the first NSAMP samples
    always_comb
    begin
        burst_sum = BSUM_W'(sample_a);
        if (NSAMP >= 2)
            burst_sum = burst_sum + BSUM_W'(sample_b);
        if (NSAMP >= 3)
            burst_sum = burst_sum + BSUM_W'(sample_c);
        if (NSAMP >= 4)
            burst_sum = burst_sum + BSUM_W'(sample_d);
        third_prod = (BSUM_W+THIRD_W)'(burst_sum) * (BSUM_W+THIRD_W)'(THIRD_Q16);
        case (NSAMP)
            1:       mean = burst_sum[CODE_W-1:0];
            2:       mean = burst_sum[CODE_W:1];
            3:       mean = third_prod[FR_W +: CODE_W];
            default: mean = burst_sum[CODE_W+1:2];
        endcase
    end

    assign old_val  = old_vld_reg ? old_reg : '0;
    assign sum_next = sum_reg - SUM_W'(old_val) + SUM_W'(mean_reg);
    assign slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;

    always_comb
    begin
        win_vld_next = win_vld_reg;
        if (cmd.upd)
            win_vld_next[slot_reg] = 1'b1;
    end

    // range check on the divided window sum
    assign code   = div_prod_reg[RECIP_SH +: CODE_W];
    assign ok     = (code >= regs.min_code) && (code <= regs.max_code);
    assign offset = code - regs.min_code;

    // round half up, saturate at the top value below the invalid mark
    assign pct_rnd = {1'b0, pct_prod_reg} + (SP_W+1)'(slpf_pkg::HALF_Q16);
    assign pct_sat = (pct_rnd[SP_W:FR_W] > (SP_W+1-FR_W)'(slpf_pkg::OUT_MAX))
                     ? slpf_pkg::OUT_MAX : pct_rnd[FR_W +: PCT_W];
    assign lvl_rnd = {1'b0, lvl_prod_reg} + (LP_W+1)'(slpf_pkg::HALF_Q16);
    assign lvl_sat = (lvl_rnd[LP_W:FR_W] > (LP_W+1-FR_W)'(slpf_pkg::OUT_MAX))
                     ? slpf_pkg::OUT_MAX : lvl_rnd[FR_W +: PCT_W];

    assign fail_inc = fail_reg + 1'b1;

    always_comb
    begin
        fail_next     = fail_reg;
        held_pct_next = held_pct_reg;
        held_lvl_next = held_lvl_reg;
        if (ok_reg)
        begin
            fail_next     = '0;
            held_pct_next = pct_reg;
            held_lvl_next = lvl_sat;
        end
        else if (fail_inc == regs.fail_limit)
        begin
            fail_next     = '0;
            held_pct_next = slpf_pkg::INVALID_MARK;
            held_lvl_next = slpf_pkg::INVALID_MARK;
        end
        else
        begin
            fail_next = fail_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            old_reg <= win_mem[slot_reg];
        if (cmd.upd)
            win_mem[slot_reg] <= mean_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            mean_reg <= mean;
        if (cmd.div)
            div_prod_reg <= DIV_W'(sum_reg) * DIV_W'(RECIP_M);
        if (cmd.check)
        begin
            code_reg     <= code;
            pct_prod_reg <= SP_W'(offset) * SP_W'(regs.slope_q16);
        end
        if (cmd.pct)
        begin
            pct_reg      <= pct_sat;
            lvl_prod_reg <= LP_W'(pct_sat) * LP_W'(regs.level_recip_q16);
        end
        if (cmd.fin)
        begin
            out_pct_reg  <= held_pct_next;
            out_lvl_reg  <= held_lvl_next;
            out_code_reg <= code_reg;
            out_ok_reg   <= ok_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_vld_reg  <= '0;
            old_vld_reg  <= 1'b0;
            slot_reg     <= '0;
            sum_reg      <= '0;
            ok_reg       <= 1'b0;
            fail_reg     <= '0;
            held_pct_reg <= slpf_pkg::INVALID_MARK;
            held_lvl_reg <= slpf_pkg::INVALID_MARK;
        end
        else
        begin
            win_vld_reg <= win_vld_next;
            if (cmd.load)
                old_vld_reg <= win_vld_reg[slot_reg];
            if (cmd.upd)
            begin
                sum_reg  <= sum_next;
                slot_reg <= slot_next;
            end
            if (cmd.check)
                ok_reg <= ok;
            if (cmd.fin)
            begin
                fail_reg     <= fail_next;
                held_pct_reg <= held_pct_next;
                held_lvl_reg <= held_lvl_next;
            end
        end
    end

    assign percent       = out_pct_reg;
    assign level         = out_lvl_reg;
    assign filtered_code = out_code_reg;
    assign in_range      = out_ok_reg;

endmodule
